// ----- design/tow_pkg.sv -----
package tow_pkg;

  localparam int TEMP_W    = 8;
  localparam int SPEED_W   = 9;
  localparam int IN_SPD_W  = 16;
  localparam int COUNT_W   = 16;
  localparam int FILT_W    = 16;
  localparam int FRAC_W    = 7;
  localparam int DELAY_W   = 7;
  localparam int IDX_W     = 3;
  localparam int MASK_W    = 4;
  localparam int LEVEL_W   = 2;
  localparam int COLOR_W   = 2;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DW    = 16;

  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 40;

  localparam logic signed [TEMP_W-1:0] TEMP_FLOOR = -8'sd127;
  localparam logic [SPEED_W-1:0]       SPEED_CLAMP = 9'd511;
  localparam logic [COUNT_W:0]         FAST_STEP   = 17'd3;
  localparam logic [COUNT_W:0]         SLOW_STEP   = 17'd1;

  // Divide by FilterDiv as multiply by a rounded-up reciprocal; exact for magnitudes
  // below 2**FiltShift / (FiltRecip * FilterDiv - 2**FiltShift), well above 2**16.
  localparam int FilterDiv = 150;
  localparam int FiltShift = 24;
  localparam int FiltRecip = ((1 << FiltShift) + FilterDiv - 1) / FilterDiv;
  localparam int RECIP_W   = 17;
  localparam int MAG_W     = FILT_W + 1;
  localparam int QUOT_W    = 10;

  localparam logic [LEVEL_W-1:0] LVL_NONE     = 2'd0;
  localparam logic [LEVEL_W-1:0] LVL_OVERHEAT = 2'd1;
  localparam logic [LEVEL_W-1:0] LVL_REDUCE   = 2'd2;

  localparam logic [COLOR_W-1:0] COLOR_WHITE  = 2'd0;
  localparam logic [COLOR_W-1:0] COLOR_YELLOW = 2'd1;
  localparam logic [COLOR_W-1:0] COLOR_RED    = 2'd2;

  localparam logic CMD_STORE = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TEMP_LOW   = 3'd0,
    REG_TEMP_MID   = 3'd1,
    REG_TEMP_HIGH  = 3'd2,
    REG_SPEED_ONE  = 3'd3,
    REG_SPEED_TWO  = 3'd4,
    REG_SPEED_THREE = 3'd5,
    REG_COUNT_MAX  = 3'd6,
    REG_WARN_EN    = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [TEMP_W-1:0]  temp_low;
    logic [TEMP_W-1:0]  temp_mid;
    logic [TEMP_W-1:0]  temp_high;
    logic [SPEED_W-1:0] speed_one;
    logic [SPEED_W-1:0] speed_two;
    logic [SPEED_W-1:0] speed_three;
    logic [COUNT_W-1:0] count_max;
    logic               warn_en;
  } cfg_t;

  typedef struct packed {
    logic [DELAY_W-1:0] red_delay;
    logic [SPEED_W-1:0] filt_speed;
    logic [COUNT_W-1:0] heat_count;
    logic [COLOR_W-1:0] color;
    logic [MASK_W-1:0]  mask;
    logic [LEVEL_W-1:0] level;
  } res_t;

endpackage

// ----- design/tow_cfg.sv -----
module tow_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [tow_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tow_pkg::CFG_DW-1:0]    cfg_wdata,
  output tow_pkg::cfg_t                 cfg
);
  import tow_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.temp_low    <= 8'd100;
      cfg_r.temp_mid    <= 8'd110;
      cfg_r.temp_high   <= 8'd120;
      cfg_r.speed_one   <= 9'd50;
      cfg_r.speed_two   <= 9'd100;
      cfg_r.speed_three <= 9'd150;
      cfg_r.count_max   <= 16'd600;
      cfg_r.warn_en     <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        REG_TEMP_LOW:    cfg_r.temp_low    <= cfg_wdata[TEMP_W-1:0];
        REG_TEMP_MID:    cfg_r.temp_mid    <= cfg_wdata[TEMP_W-1:0];
        REG_TEMP_HIGH:   cfg_r.temp_high   <= cfg_wdata[TEMP_W-1:0];
        REG_SPEED_ONE:   cfg_r.speed_one   <= cfg_wdata[SPEED_W-1:0];
        REG_SPEED_TWO:   cfg_r.speed_two   <= cfg_wdata[SPEED_W-1:0];
        REG_SPEED_THREE: cfg_r.speed_three <= cfg_wdata[SPEED_W-1:0];
        REG_COUNT_MAX:   cfg_r.count_max   <= cfg_wdata[COUNT_W-1:0];
        REG_WARN_EN:     cfg_r.warn_en     <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- design/tow_speed_filt.sv -----
module tow_speed_filt (
  input  logic [tow_pkg::FILT_W-1:0]   filt_q7,
  input  logic [tow_pkg::IN_SPD_W-1:0] speed_kmh,
  output logic [tow_pkg::FILT_W-1:0]   filt_nxt,
  output logic [tow_pkg::SPEED_W-1:0]  eff_speed
);
  import tow_pkg::*;

  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(FiltRecip);

  logic [SPEED_W-1:0]       cur;
  logic [FILT_W-1:0]        target;
  logic signed [FILT_W+1:0] diff;
  logic [MAG_W-1:0]         mag;
  logic [MAG_W+RECIP_W-1:0] prod;
  logic [QUOT_W-1:0]        quot;
  logic [FILT_W-1:0]        step;
  logic [SPEED_W-1:0]       filt_speed;

  always_comb begin
    cur    = (speed_kmh > IN_SPD_W'(SPEED_CLAMP)) ? SPEED_CLAMP : speed_kmh[SPEED_W-1:0];
    target = {cur, {FRAC_W{1'b0}}};
    diff   = $signed({2'b00, target}) - $signed({2'b00, filt_q7});
    mag    = diff[FILT_W+1] ? MAG_W'(-diff) : MAG_W'(diff);
    prod   = mag * RECIP;
    quot   = prod[FiltShift +: QUOT_W];
    // truncate toward zero: negate the magnitude quotient for a falling target
    step   = diff[FILT_W+1] ? -FILT_W'(quot) : FILT_W'(quot);
    filt_nxt   = filt_q7 + step;
    filt_speed = filt_nxt[FILT_W-1:FRAC_W];
    eff_speed  = (cur < filt_speed) ? cur : filt_speed;
  end

endmodule

// ----- design/tow_heat.sv -----
module tow_heat #(
  parameter int NUM_WHEELS      = 4,
  parameter int RED_DELAY_TICKS = 120
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  tow_pkg::cfg_t                cfg,
  input  logic                         item_en,
  input  logic                         cmd,
  input  logic [tow_pkg::IDX_W-1:0]    wheel_index,
  input  logic [tow_pkg::TEMP_W-1:0]   temperature,
  input  logic [tow_pkg::IN_SPD_W-1:0] speed_kmh,
  output tow_pkg::res_t                res
);
  import tow_pkg::*;

  localparam logic [DELAY_W-1:0] DELAY_LAST = DELAY_W'(RED_DELAY_TICKS);

  logic signed [TEMP_W-1:0] temps_r   [NUM_WHEELS];
  logic signed [TEMP_W-1:0] temps_nxt [NUM_WHEELS];
  logic [COUNT_W-1:0]       heat_r, heat_nxt;
  logic [FILT_W-1:0]        filt_r, filt_nxt, filt_calc;
  logic                     over_r, over_nxt;
  logic                     red_r, red_nxt;
  logic [DELAY_W-1:0]       delay_r, delay_nxt;
  logic [SPEED_W-1:0]       fs;
  logic signed [TEMP_W-1:0] mt;
  logic signed [TEMP_W-1:0] t_low, t_mid, t_high;
  logic [COUNT_W:0]         hmax_x, up1, up3, dn1;
  logic [MASK_W-1:0]        hot_mask;
  logic                     is_tick;

  tow_speed_filt u_filt (
    .filt_q7   (filt_r),
    .speed_kmh (speed_kmh),
    .filt_nxt  (filt_calc),
    .eff_speed (fs)
  );

  always_comb begin
    for (int i = 0; i < NUM_WHEELS; i++) begin
      temps_nxt[i] = temps_r[i];
      if (cmd == CMD_STORE && wheel_index == IDX_W'(i)) begin
        temps_nxt[i] = temperature;
      end
    end
    mt = TEMP_FLOOR;
    for (int i = 0; i < NUM_WHEELS; i++) begin
      if (temps_nxt[i] > mt) begin
        mt = temps_nxt[i];
      end
    end
  end

  for (genvar g = 0; g < MASK_W; g++) begin : g_mask
    if (g < NUM_WHEELS) begin : g_on
      assign hot_mask[g] = (temps_nxt[g] == mt);
    end else begin : g_off
      assign hot_mask[g] = 1'b0;
    end
  end

  always_comb begin
    is_tick = (cmd == CMD_TICK);
    t_low   = cfg.temp_low;
    t_mid   = cfg.temp_mid;
    t_high  = cfg.temp_high;
    hmax_x  = {1'b0, cfg.count_max};
    up1     = ({1'b0, heat_r} + SLOW_STEP > hmax_x) ? hmax_x : {1'b0, heat_r} + SLOW_STEP;
    up3     = ({1'b0, heat_r} + FAST_STEP > hmax_x) ? hmax_x : {1'b0, heat_r} + FAST_STEP;
    dn1     = (heat_r != '0) ? {1'b0, heat_r} - SLOW_STEP : '0;

    heat_nxt  = heat_r;
    filt_nxt  = filt_r;
    over_nxt  = over_r;
    red_nxt   = red_r;
    delay_nxt = delay_r;

    if (is_tick) begin
      filt_nxt = filt_calc;
      if (cfg.speed_one >= fs) begin
        heat_nxt = (t_high < mt) ? dn1[COUNT_W-1:0] : '0;
      end else if (cfg.speed_two >= fs) begin
        if (t_mid > mt) begin
          heat_nxt = '0;
        end else if (t_high < mt) begin
          heat_nxt = up1[COUNT_W-1:0];
        end
      end else if (cfg.speed_three >= fs) begin
        if (t_mid > mt) begin
          heat_nxt = dn1[COUNT_W-1:0];
        end else if (t_high < mt) begin
          heat_nxt = up3[COUNT_W-1:0];
        end else begin
          heat_nxt = up1[COUNT_W-1:0];
        end
      end else begin
        if (t_mid > mt) begin
          heat_nxt = dn1[COUNT_W-1:0];
        end else if (t_high < mt) begin
          heat_nxt = cfg.count_max;
        end else begin
          heat_nxt = up3[COUNT_W-1:0];
        end
      end

      if (t_low > mt) begin
        over_nxt = 1'b0;
      end else if (cfg.count_max <= heat_nxt) begin
        over_nxt = 1'b1;
      end

      red_nxt = 1'b0;
      if (cfg.count_max == heat_nxt) begin
        if (delay_r < DELAY_LAST) begin
          delay_nxt = delay_r + 1'b1;
        end else if (cfg.speed_three < fs && t_high <= mt) begin
          red_nxt = 1'b1;
        end else if (red_r && cfg.speed_one < fs) begin
          red_nxt = 1'b1;
        end
      end else begin
        delay_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_WHEELS; i++) begin
        temps_r[i] <= TEMP_FLOOR;
      end
      heat_r  <= '0;
      filt_r  <= '0;
      over_r  <= 1'b0;
      red_r   <= 1'b0;
      delay_r <= '0;
    end else if (item_en) begin
      temps_r <= temps_nxt;
      heat_r  <= heat_nxt;
      filt_r  <= filt_nxt;
      over_r  <= over_nxt;
      red_r   <= red_nxt;
      delay_r <= delay_nxt;
    end
  end

  always_comb begin
    res.level = LVL_NONE;
    res.mask  = '0;
    if (cfg.warn_en) begin
      res.level = red_nxt ? LVL_REDUCE : (over_nxt ? LVL_OVERHEAT : LVL_NONE);
      if (over_nxt) begin
        res.mask = hot_mask;
      end
    end
    if (t_mid <= mt) begin
      res.color = COLOR_RED;
    end else if (t_low > mt) begin
      res.color = COLOR_WHITE;
    end else begin
      res.color = COLOR_YELLOW;
    end
    res.heat_count = heat_nxt;
    res.filt_speed = filt_nxt[FILT_W-1:FRAC_W];
    res.red_delay  = delay_nxt;
  end

endmodule

// ----- design/tire_overheat_warning.sv -----
// Tire overheat warning. Takes one item per clock while out_tready stays high:
// a store item (in_tuser low) writes one wheel temperature, a tick item (in_tuser high,
// once per second) filters the speed and moves the heat counter, the overheat warning
// and the reduce-speed delay. Every item returns one result: the input register feeds a
// single pass of compare, add and one multiply (the divide by 150 of the speed filter)
// into the result register, so the sustained rate is one item per cycle while out_tready
// stays high. Configure only while no item is in flight.
module tire_overheat_warning #(
  parameter int NUM_WHEELS      = 4,
  parameter int RED_DELAY_TICKS = 120
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // wheel_index, temperature, speed_kmh, zero pad
  input  logic [tow_pkg::IN_DATA_W-1:0]   in_tdata,
  // cmd
  input  logic [0:0]                      in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // warning_level, hot_wheel_mask, hot_color, heat_count, filtered_speed, red_delay_count
  output logic [tow_pkg::OUT_DATA_W-1:0]  out_tdata,
  input  logic                            cfg_we,
  input  logic [tow_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tow_pkg::CFG_DW-1:0]      cfg_wdata
);
  import tow_pkg::*;

  cfg_t                cfg;
  res_t                res;
  logic                s1_valid_r;
  logic                s1_cmd_r;
  logic [IDX_W-1:0]    s1_idx_r;
  logic [TEMP_W-1:0]   s1_temp_r;
  logic [IN_SPD_W-1:0] s1_speed_r;
  logic                out_valid_r;
  res_t                out_res_r;
  logic                advance;
  logic                in_xfer;

  tow_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  tow_heat #(
    .NUM_WHEELS      (NUM_WHEELS),
    .RED_DELAY_TICKS (RED_DELAY_TICKS)
  ) u_heat (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg),
    .item_en     (advance),
    .cmd         (s1_cmd_r),
    .wheel_index (s1_idx_r),
    .temperature (s1_temp_r),
    .speed_kmh   (s1_speed_r),
    .res         (res)
  );

  assign advance   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || advance;
  assign in_xfer   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_cmd_r   <= in_tuser[0];
      s1_idx_r   <= in_tdata[IDX_W-1:0];
      s1_temp_r  <= in_tdata[IDX_W +: TEMP_W];
      s1_speed_r <= in_tdata[IDX_W+TEMP_W +: IN_SPD_W];
    end
    if (advance) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_res_r;

`ifndef SYNTHESIS
  a_delay_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_res_r.red_delay <= DELAY_W'(RED_DELAY_TICKS)))
    else $error("red delay count above its limit");

  a_level_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_res_r.level <= LVL_REDUCE))
    else $error("warning level code out of range");

  a_mask_needs_level: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_res_r.mask != '0) |-> (out_res_r.level != LVL_NONE))
    else $error("hot wheel mask without warning");

  a_hold_full: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && !out_tready) |-> !in_tready)
    else $error("input taken while both stages are stalled");
`endif

endmodule

// ----- dv/tire_overheat_warning_checker.sv -----
module tire_overheat_warning_checker #(
  parameter int NUM_WHEELS      = 4,
  parameter int RED_DELAY_TICKS = 120
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  // wheel_index, temperature, speed_kmh, zero pad
  input  logic [tow_pkg::IN_DATA_W-1:0]  in_tdata,
  // cmd
  input  logic [0:0]                     in_tuser,
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  // warning_level, hot_wheel_mask, hot_color, heat_count, filtered_speed, red_delay_count
  input  logic [tow_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                           cfg_we,
  input  logic [tow_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tow_pkg::CFG_DW-1:0]     cfg_wdata,
  output int                             fail_count,
  output int                             outstanding
);
  import tow_pkg::*;

  localparam int TEMP_LSB  = IDX_W;
  localparam int SPEED_LSB = IDX_W + TEMP_W;

  logic [TEMP_W-1:0]         temp_low, temp_mid, temp_high;
  logic [SPEED_W-1:0]        band_one, band_two, band_three;
  logic [COUNT_W-1:0]        count_max;
  logic                      warn_en;

  logic signed [TEMP_W-1:0]  wheel_temp [NUM_WHEELS];
  logic [COUNT_W-1:0]        heat;
  logic [FILT_W-1:0]         filt_q7;
  logic                      overheat;
  logic                      red_speed;
  logic [DELAY_W-1:0]        red_delay;

  res_t                      status_q [$];
  logic [IDX_W-1:0]          wheel_sel;

  task automatic clear_state();
    temp_low   = 8'd100;
    temp_mid   = 8'd110;
    temp_high  = 8'd120;
    band_one   = 9'd50;
    band_two   = 9'd100;
    band_three = 9'd150;
    count_max  = 16'd600;
    warn_en    = 1'b1;
    for (int i = 0; i < NUM_WHEELS; i++) wheel_temp[i] = TEMP_FLOOR;
    heat      = '0;
    filt_q7   = '0;
    overheat  = 1'b0;
    red_speed = 1'b0;
    red_delay = '0;
  endtask

  function automatic int hottest();
    int m;
    m = TEMP_FLOOR;
    for (int i = 0; i < NUM_WHEELS; i++)
      if (int'(wheel_temp[i]) > m) m = int'(wheel_temp[i]);
    return m;
  endfunction

  task automatic raise_heat(input int step);
    int s;
    s = int'(heat) + step;
    heat = (s > int'(count_max)) ? count_max : s[COUNT_W-1:0];
  endtask

  task automatic lower_heat(input int step);
    heat = (int'(heat) > step) ? heat - step[COUNT_W-1:0] : '0;
  endtask

  task automatic run_tick(input logic [IN_SPD_W-1:0] speed);
    int  mt, t0, t1, t2, b1, b2, b3, cur, diff, nf, fs;
    bit  red;
    mt   = hottest();
    t0   = int'($signed(temp_low));
    t1   = int'($signed(temp_mid));
    t2   = int'($signed(temp_high));
    b1   = int'(band_one);
    b2   = int'(band_two);
    b3   = int'(band_three);
    cur  = (int'(speed) > int'(SPEED_CLAMP)) ? int'(SPEED_CLAMP) : int'(speed);
    diff = (cur << FRAC_W) - int'(filt_q7);
    nf   = int'(filt_q7) + diff / FilterDiv;
    filt_q7 = nf[FILT_W-1:0];
    fs = int'(filt_q7 >> FRAC_W);
    if (cur < fs) fs = cur;

    if (b1 >= fs) begin
      if (t2 < mt) lower_heat(int'(SLOW_STEP));
      else heat = '0;
    end else if (b2 >= fs) begin
      if (t1 > mt) heat = '0;
      else if (t2 < mt) raise_heat(int'(SLOW_STEP));
    end else if (b3 >= fs) begin
      if (t1 > mt) lower_heat(int'(SLOW_STEP));
      else if (t2 < mt) raise_heat(int'(FAST_STEP));
      else raise_heat(int'(SLOW_STEP));
    end else begin
      if (t1 > mt) lower_heat(int'(SLOW_STEP));
      else if (t2 < mt) heat = count_max;
      else raise_heat(int'(FAST_STEP));
    end

    if (t0 > mt) overheat = 1'b0;
    else if (count_max <= heat) overheat = 1'b1;

    red = 1'b0;
    if (count_max == heat) begin
      if (int'(red_delay) < RED_DELAY_TICKS) red_delay = red_delay + 1'b1;
      else if (b3 < fs && t2 <= mt) red = 1'b1;
      else if (red_speed && b1 < fs) red = 1'b1;
    end else begin
      red_delay = '0;
    end
    red_speed = red;
  endtask

  function automatic res_t status_now();
    res_t r;
    int   mt;
    r  = '0;
    mt = hottest();
    if (warn_en) begin
      r.level = red_speed ? LVL_REDUCE : (overheat ? LVL_OVERHEAT : LVL_NONE);
      if (overheat)
        for (int i = 0; i < NUM_WHEELS && i < MASK_W; i++)
          if (int'(wheel_temp[i]) == mt) r.mask[i] = 1'b1;
    end
    if (int'($signed(temp_mid)) <= mt) r.color = COLOR_RED;
    else if (int'($signed(temp_low)) > mt) r.color = COLOR_WHITE;
    else r.color = COLOR_YELLOW;
    r.heat_count = heat;
    r.filt_speed = filt_q7[FILT_W-1:FRAC_W];
    r.red_delay  = red_delay;
    return r;
  endfunction

  task automatic compare_status(input res_t got);
    res_t want;
    if (status_q.size() == 0) begin
      $error("result transfer with no expected status: %h", got);
      fail_count++;
    end else begin
      want = status_q.pop_front();
      if (got.level !== want.level) begin
        $error("warning_level: expected %0d, actual %0d", want.level, got.level);
        fail_count++;
      end
      if (got.mask !== want.mask) begin
        $error("hot_wheel_mask: expected %0h, actual %0h", want.mask, got.mask);
        fail_count++;
      end
      if (got.color !== want.color) begin
        $error("hot_color: expected %0d, actual %0d", want.color, got.color);
        fail_count++;
      end
      if (got.heat_count !== want.heat_count) begin
        $error("heat_count: expected %0d, actual %0d", want.heat_count, got.heat_count);
        fail_count++;
      end
      if (got.filt_speed !== want.filt_speed) begin
        $error("filtered_speed: expected %0d, actual %0d", want.filt_speed, got.filt_speed);
        fail_count++;
      end
      if (got.red_delay !== want.red_delay) begin
        $error("red_delay_count: expected %0d, actual %0d", want.red_delay, got.red_delay);
        fail_count++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_state();
      status_q.delete();
    end else begin
      if (out_tvalid && out_tready) compare_status(res_t'(out_tdata));
      if (cfg_we) begin
        case (cfg_index)
          REG_TEMP_LOW:    temp_low   = cfg_wdata[TEMP_W-1:0];
          REG_TEMP_MID:    temp_mid   = cfg_wdata[TEMP_W-1:0];
          REG_TEMP_HIGH:   temp_high  = cfg_wdata[TEMP_W-1:0];
          REG_SPEED_ONE:   band_one   = cfg_wdata[SPEED_W-1:0];
          REG_SPEED_TWO:   band_two   = cfg_wdata[SPEED_W-1:0];
          REG_SPEED_THREE: band_three = cfg_wdata[SPEED_W-1:0];
          REG_COUNT_MAX:   count_max  = cfg_wdata[COUNT_W-1:0];
          REG_WARN_EN:     warn_en    = cfg_wdata[0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        if (in_tuser[0] == CMD_STORE) begin
          wheel_sel = in_tdata[IDX_W-1:0];
          if (int'(wheel_sel) < NUM_WHEELS)
            wheel_temp[wheel_sel] = in_tdata[SPEED_LSB-1:TEMP_LSB];
        end else begin
          run_tick(in_tdata[SPEED_LSB+IN_SPD_W-1:SPEED_LSB]);
        end
        status_q.push_back(status_now());
      end
    end
    outstanding = status_q.size();
  end

endmodule

// ----- dv/tire_overheat_warning_tb.sv -----
module tire_overheat_warning_tb;
  import tow_pkg::*;

  localparam int NUM_PHASES = 10;
  localparam int PHASE_LEN  = 193;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic [0:0]            in_tuser;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DW-1:0]     cfg_wdata;

  int fail_count;
  int outstanding;
  bit stall_en;
  int stall_left;
  int lim_low, lim_mid, lim_high;
  int base_speed;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  tire_overheat_warning dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  tire_overheat_warning_checker checker_i (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  // hold off the result channel in random bursts
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (stall_en && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 9);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic send_item(input logic cmd, input logic [IDX_W-1:0] wi,
                           input logic [TEMP_W-1:0] tc, input logic [IN_SPD_W-1:0] spd);
    @(negedge clk);
    if (stall_en && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {{(IN_DATA_W-IDX_W-TEMP_W-IN_SPD_W){1'b0}}, spd, tc, wi};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    wait (outstanding == 0);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input int val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[CFG_DW-1:0];
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic configure(input int lo, input int mid, input int hi, input int b1,
                           input int b2, input int b3, input int hmax, input int en);
    write_reg(REG_TEMP_LOW, lo);
    write_reg(REG_TEMP_MID, mid);
    write_reg(REG_TEMP_HIGH, hi);
    write_reg(REG_SPEED_ONE, b1);
    write_reg(REG_SPEED_TWO, b2);
    write_reg(REG_SPEED_THREE, b3);
    write_reg(REG_COUNT_MAX, hmax);
    write_reg(REG_WARN_EN, en);
    lim_low  = lo;
    lim_mid  = mid;
    lim_high = hi;
  endtask

  task automatic random_config(input int en);
    int lo, mid, hi, b1, b2, b3, hmax;
    if ($urandom_range(0, 3) == 0) begin
      lo  = $urandom_range(0, 255) - 128;
      mid = $urandom_range(0, 255) - 128;
      hi  = $urandom_range(0, 255) - 128;
    end else begin
      lo  = $urandom_range(40, 115);
      mid = lo + $urandom_range(0, 6);
      hi  = mid + $urandom_range(0, 6);
    end
    if ($urandom_range(0, 3) == 0) begin
      b1 = $urandom_range(0, 511);
      b2 = $urandom_range(0, 511);
      b3 = $urandom_range(0, 511);
    end else begin
      b1 = $urandom_range(0, 60);
      b2 = b1 + $urandom_range(0, 60);
      b3 = b2 + $urandom_range(0, 80);
    end
    case ($urandom_range(0, 5))
      0:       hmax = 65535;
      1:       hmax = 1;
      2:       hmax = $urandom_range(1, 65535);
      default: hmax = $urandom_range(1, 30);
    endcase
    configure(lo, mid, hi, b1, b2, b3, hmax, en);
  endtask

  function automatic logic [TEMP_W-1:0] pick_temp();
    int v;
    case ($urandom_range(0, 9))
      0:       v = $urandom_range(0, 255) - 128;
      1:       v = $urandom_range(0, 1) ? 127 : -128;
      2:       v = lim_low + $urandom_range(0, 8) - 4;
      3, 4:    v = lim_mid + $urandom_range(0, 8) - 4;
      default: v = lim_high + $urandom_range(0, 10) - 3;
    endcase
    if (v > 127) v = 127;
    if (v < -128) v = -128;
    return v[TEMP_W-1:0];
  endfunction

  function automatic logic [IN_SPD_W-1:0] pick_speed();
    int v;
    case ($urandom_range(0, 31))
      0:       v = 0;
      1:       v = 65535;
      2, 3:    v = $urandom_range(0, 65535);
      default: v = base_speed + $urandom_range(0, 40) - 20;
    endcase
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return v[IN_SPD_W-1:0];
  endfunction

  function automatic int pick_base();
    case ($urandom_range(0, 5))
      0:       return 0;
      1:       return 65535;
      2:       return $urandom_range(0, 160);
      default: return $urandom_range(150, 600);
    endcase
  endfunction

  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = CMD_STORE;
    cfg_we     = 1'b0;
    cfg_index  = '0;
    cfg_wdata  = '0;
    stall_en   = 1'b1;
    stall_left = 0;
    lim_low    = 100;
    lim_mid    = 110;
    lim_high   = 120;
    base_speed = 300;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    send_item(CMD_STORE, 3'd0, 8'sd127, 16'hFFFF);
    send_item(CMD_STORE, 3'd1, -8'sd128, 16'h0000);
    send_item(CMD_STORE, 3'd2, 8'sd0, 16'h1234);
    send_item(CMD_STORE, 3'd3, 8'sd100, 16'h8001);
    send_item(CMD_STORE, 3'd4, 8'sd127, 16'h0000);
    send_item(CMD_STORE, 3'd7, -8'sd128, 16'hFFFF);
    send_item(CMD_TICK, 3'd0, 8'sd0, 16'd0);
    send_item(CMD_TICK, 3'd7, 8'hFF, 16'hFFFF);
    send_item(CMD_TICK, 3'd0, 8'sd0, 16'd511);
    send_item(CMD_TICK, 3'd0, 8'sd0, 16'd512);
    for (int w = 0; w < 4; w++) send_item(CMD_STORE, w[IDX_W-1:0], -8'sd128, 16'd0);
    send_item(CMD_TICK, 3'd0, 8'sd0, 16'd300);
    send_item(CMD_TICK, 3'd0, 8'sd0, 16'd1);
    send_item(CMD_STORE, 3'd2, 8'sd110, 16'd0);
    send_item(CMD_STORE, 3'd3, 8'sd110, 16'd0);
    send_item(CMD_STORE, 3'd5, 8'sd120, 16'd0);
    for (int k = 0; k < 3; k++) send_item(CMD_TICK, 3'd0, 8'sd0, 16'd200);
    send_item(CMD_STORE, 3'd6, 8'sd0, 16'd0);

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      drain();
      stall_en = (phase != NUM_PHASES - 1) && ($urandom_range(0, 3) != 0);
      case (phase)
        0: begin
          configure(-128, -128, -128, 0, 0, 0, 65535, 1);
          base_speed = 511;
        end
        1: begin
          configure(60, 70, 80, 0, 0, 511, 1, 1);
          base_speed = 300;
        end
        2: begin
          configure(127, 127, 127, 511, 511, 511, 600, 0);
          base_speed = pick_base();
        end
        3: begin
          random_config(0);
          base_speed = pick_base();
        end
        default: begin
          random_config($urandom_range(0, 4) != 0);
          base_speed = pick_base();
        end
      endcase
      for (int n = 0; n < PHASE_LEN; n++) begin
        if ($urandom_range(0, 39) == 0) base_speed = pick_base();
        if ($urandom_range(0, 4) == 0)
          send_item(CMD_STORE,
                    ($urandom_range(0, 7) != 0) ? 3'($urandom_range(0, 3))
                                                : 3'($urandom_range(4, 7)),
                    pick_temp(), 16'($urandom));
        else
          send_item(CMD_TICK, 3'($urandom), 8'($urandom), pick_speed());
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (fail_count == 0 && outstanding == 0)
      $display("tire_overheat_warning_tb passed");
    else
      $display("tire_overheat_warning_tb failed");
    $finish;
  end

  initial begin
    #5000000;
    $display("tire_overheat_warning_tb failed");
    $finish;
  end

endmodule
